### rtl/ede_pkg.sv
package ede_pkg;

   localparam int MAX_LEN = 64;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DIST_W  = 7;
   localparam int DIST_MAX = (1 << DIST_W) - 1;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_FEED   = 2'd2;
   localparam logic [1:0] CMD_REPORT = 2'd3;

   typedef logic [LEN_W-1:0] cost_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              truncated;
   } rsp_type;

   // one query byte travelling along the row
   typedef struct packed {
      logic       valid;
      logic [7:0] sym;
      cost_type   left;
      cost_type   diag;
   } token_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic [7:0] load_sym;
      cost_type   ref_len;
   } cell_ctrl_type;

   function automatic logic [DIST_W-1:0] sat_distance(input cost_type c);
      logic [DIST_W-1:0] d;
      if (LEN_W > DIST_W && int'(c) > DIST_MAX) begin
         d = DIST_W'(DIST_MAX);
      end else begin
         d = DIST_W'(c);
      end
      return d;
   endfunction

endpackage

### rtl/ede_cell.sv
module ede_cell
   import ede_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  cell_ctrl_type ctrl,
   input  token_type     tok_in,
   output token_type     tok_out,
   output cost_type      last_cost
);

   logic [7:0] ref_ff;
   cost_type   cost_ff, cost_in;
   token_type  tok_ff;
   cost_type   own_pos;
   cost_type   m1, m2;

   assign own_pos = cost_type'(cell_idx) + cost_type'(1);

   always_comb begin
      m1 = (cost_ff < tok_in.left) ? cost_ff : tok_in.left;
      m2 = (m1 < tok_in.diag) ? m1 : tok_in.diag;
      if (ref_ff == tok_in.sym) begin
         cost_in = tok_in.diag;
      end else begin
         cost_in = m2 + cost_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load && ctrl.ref_len == cost_type'(cell_idx)) begin
         ref_ff <= ctrl.load_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         cost_ff      <= own_pos;
         tok_ff.valid <= 1'b0;
      end else begin
         if (tok_in.valid) begin
            cost_ff <= cost_in;
         end
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.sym  <= tok_in.sym;
      tok_ff.left <= cost_in;
      tok_ff.diag <= cost_ff;
   end

   assign tok_out   = tok_ff;
   assign last_cost = (ctrl.ref_len == own_pos) ? cost_ff : '0;

endmodule

### rtl/edit_distance_engine_top.sv
// Levenshtein edit distance engine.
// req channel: one word per command (clear, append first-string byte, feed
// second-string byte, report). rsp channel: one word per report, carrying the
// distance and the truncated flag. A word moves when valid is high and stall
// is low.
// The first string sits in a row of MAX_LEN cells, one byte and one row cost
// each. A fed byte enters the row as a token and moves one cell per cycle, so
// feed words are taken back to back, one per cycle.
// A report waits until the last fed token has left the row, otherwise it is
// taken at once. The result word appears in the cycle after the report is
// taken and is held while rsp_stall is high; a new report is stalled until
// the held word is taken. Clear, append and feed words are never stalled.
// Reset (and clear) returns every cost to its position, empties the row and
// zeroes both lengths and the truncated flag; stored first-string bytes keep
// their contents but are not read until written again.
module edit_distance_engine_top
   import ede_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cost_type      ref_len_ff, ref_len_in;
   cost_type      qry_len_ff, qry_len_in;
   logic          ovf_ff, ovf_in;
   cost_type      drain_ff, drain_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;
   token_type     tok_ff;
   logic          req_fire, do_clear, do_load, do_feed, do_report;
   cell_ctrl_type ctrl;
   token_type     chain [MAX_LEN+1];
   cost_type      cost_sel [MAX_LEN];
   cost_type      tail_cost;

   assign req_stall = (req_data.cmd == CMD_REPORT) &&
                      ((drain_ff != '0) || (rsp_valid_ff && rsp_stall));
   assign req_fire  = req_valid && !req_stall;
   assign do_clear  = req_fire && req_data.cmd == CMD_CLEAR;
   assign do_load   = req_fire && req_data.cmd == CMD_APPEND && qry_len_ff == '0 &&
                      ref_len_ff != cost_type'(MAX_LEN);
   assign do_feed   = req_fire && req_data.cmd == CMD_FEED &&
                      qry_len_ff != cost_type'(MAX_LEN);
   assign do_report = req_fire && req_data.cmd == CMD_REPORT;

   always_comb begin
      ref_len_in = ref_len_ff;
      qry_len_in = qry_len_ff;
      ovf_in     = ovf_ff;
      drain_in   = (drain_ff != '0) ? drain_ff - cost_type'(1) : drain_ff;
      if (req_fire) begin
         unique case (req_data.cmd)
            CMD_CLEAR: begin
               ref_len_in = '0;
               qry_len_in = '0;
               ovf_in     = 1'b0;
               drain_in   = '0;
            end
            CMD_APPEND: begin
               if (qry_len_ff == '0) begin
                  if (ref_len_ff == cost_type'(MAX_LEN)) begin
                     ovf_in = 1'b1;
                  end else begin
                     ref_len_in = ref_len_ff + cost_type'(1);
                  end
               end
            end
            CMD_FEED: begin
               if (qry_len_ff == cost_type'(MAX_LEN)) begin
                  ovf_in = 1'b1;
               end else begin
                  qry_len_in = qry_len_ff + cost_type'(1);
                  drain_in   = cost_type'(MAX_LEN);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff   <= '0;
         qry_len_ff   <= '0;
         ovf_ff       <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         ref_len_ff   <= ref_len_in;
         qry_len_ff   <= qry_len_in;
         ovf_ff       <= ovf_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         tok_ff.valid <= do_feed;
      end
      // row entry zero is the query length itself
      tok_ff.sym  <= req_data.symbol;
      tok_ff.left <= qry_len_ff + cost_type'(1);
      tok_ff.diag <= qry_len_ff;
   end

   assign ctrl.clear    = do_clear;
   assign ctrl.load     = do_load;
   assign ctrl.load_sym = req_data.symbol;
   assign ctrl.ref_len  = ref_len_ff;

   assign chain[0] = tok_ff;

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      ede_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(i)),
         .ctrl      (ctrl),
         .tok_in    (chain[i]),
         .tok_out   (chain[i+1]),
         .last_cost (cost_sel[i])
      );
   end

   always_comb begin
      tail_cost = (ref_len_ff == '0) ? qry_len_ff : '0;
      for (int i = 0; i < MAX_LEN; i++) begin
         tail_cost = tail_cost | cost_sel[i];
      end
   end

   assign rsp_valid_in = do_report ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (do_report) begin
         rsp_ff.distance  <= sat_distance(tail_cost);
         rsp_ff.truncated <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### tb/edit_distance_checker.sv
`timescale 1ns / 100ps
module edit_distance_checker
   import ede_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   logic [7:0] first_str [MAX_LEN];
   int         first_len;
   int         second_len;
   bit         dropped;
   int         row_cost [MAX_LEN+1];
   rsp_type    due_scores [$];
   int         fail_count;

   task automatic restart_pair();
      first_len  = 0;
      second_len = 0;
      dropped    = 1'b0;
      for (int i = 0; i <= MAX_LEN; i++) row_cost[i] = i;
   endtask

   task automatic absorb_command(input req_type w);
      int      diag;
      int      up;
      int      best_cost;
      int      capped;
      rsp_type score;
      case (w.cmd)
         CMD_CLEAR: begin
            restart_pair();
         end
         CMD_APPEND: begin
            if (second_len == 0) begin
               if (first_len >= MAX_LEN) begin
                  dropped = 1'b1;
               end else begin
                  first_str[first_len] = w.symbol;
                  first_len++;
               end
            end
         end
         CMD_FEED: begin
            if (second_len >= MAX_LEN) begin
               dropped = 1'b1;
            end else begin
               diag        = row_cost[0];
               row_cost[0] = diag + 1;
               for (int i = 1; i <= first_len; i++) begin
                  up = row_cost[i];
                  if (first_str[i-1] == w.symbol) begin
                     best_cost = diag;
                  end else begin
                     best_cost = up;
                     if (row_cost[i-1] < best_cost) best_cost = row_cost[i-1];
                     if (diag < best_cost) best_cost = diag;
                     best_cost = best_cost + 1;
                  end
                  diag        = up;
                  row_cost[i] = best_cost;
               end
               second_len++;
            end
         end
         CMD_REPORT: begin
            capped = row_cost[first_len];
            if (capped > DIST_MAX) capped = DIST_MAX;
            score.distance  = DIST_W'(capped);
            score.truncated = dropped;
            due_scores = {due_scores, score};
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         restart_pair();
         due_scores.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_scores.size() == 0) begin
               $display("%0t: unexpected word: expected none, got distance %0d truncated %0b",
                        $time, rsp_data.distance, rsp_data.truncated);
               fail_count++;
            end else begin
               want = due_scores.pop_front();
               if (rsp_data.distance !== want.distance) begin
                  $display("%0t: distance mismatch: expected %0d, got %0d",
                           $time, want.distance, rsp_data.distance);
                  fail_count++;
               end
               if (rsp_data.truncated !== want.truncated) begin
                  $display("%0t: truncated mismatch: expected %0b, got %0b",
                           $time, want.truncated, rsp_data.truncated);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) absorb_command(req_data);
      end
      mismatches  <= fail_count;
      outstanding <= due_scores.size();
   end

endmodule

### tb/tb_edit_distance_engine_top.sv
`timescale 1ns / 100ps
module tb_edit_distance_engine_top;
   import ede_pkg::*;

   localparam int WORD_TARGET  = 1700;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_AT      = 20;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int         mismatches;
   int         outstanding;
   int         words_sent  = 0;
   int         quiet_count = 0;
   int         taken       = 0;
   bit         tx_burst    = 1'b0;
   bit         rx_burst    = 1'b0;
   bit         narrow_set  = 1'b0;
   logic [7:0] alphabet [4];

   edit_distance_engine_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   edit_distance_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic logic [7:0] draw_symbol();
      logic [7:0] s;
      if (narrow_set) s = alphabet[$urandom_range(0, 3)];
      else s = 8'($urandom);
      return s;
   endfunction

   function automatic int draw_length();
      int n;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
      else n = $urandom_range(0, 12);
      return n;
   endfunction

   task automatic put_word(input logic [1:0] cmd, input logic [7:0] sym, input bit counts);
      int      gap;
      req_type w;
      gap = tx_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.cmd    = cmd;
      w.symbol = sym;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      if (counts) words_sent++;
      if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
   endtask

   task automatic run_pair();
      int first_n;
      int second_n;
      first_n    = draw_length();
      second_n   = draw_length();
      narrow_set = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom);
      put_word(CMD_CLEAR, 8'($urandom), 1'b1);
      repeat (first_n) put_word(CMD_APPEND, draw_symbol(), 1'b1);
      for (int q = 0; q < second_n; q++) begin
         put_word(CMD_FEED, draw_symbol(), 1'b1);
         if ($urandom_range(0, 5) == 0) put_word(CMD_REPORT, 8'($urandom), 1'b1);
         // late first-string byte, ignored by the block
         if ($urandom_range(0, 19) == 0) put_word(CMD_APPEND, 8'($urandom), 1'b0);
      end
      put_word(CMD_REPORT, 8'($urandom), 1'b1);
   endtask

   initial begin
      int noise_n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put_word(CMD_REPORT, 8'hFF, 1'b1);
      put_word(CMD_APPEND, 8'h00, 1'b1);
      put_word(CMD_APPEND, 8'hFF, 1'b1);
      put_word(CMD_REPORT, 8'h00, 1'b1);
      put_word(CMD_FEED,   8'hFF, 1'b1);
      put_word(CMD_FEED,   8'h00, 1'b1);
      put_word(CMD_REPORT, 8'h55, 1'b1);
      put_word(CMD_APPEND, 8'h55, 1'b0);
      put_word(CMD_REPORT, 8'hAA, 1'b1);
      put_word(CMD_FEED,   8'hAA, 1'b1);
      put_word(CMD_REPORT, 8'h00, 1'b1);
      put_word(CMD_CLEAR,  8'hAA, 1'b1);
      put_word(CMD_FEED,   8'h55, 1'b1);
      put_word(CMD_FEED,   8'hAA, 1'b1);
      put_word(CMD_REPORT, 8'h00, 1'b1);
      put_word(CMD_REPORT, 8'hFF, 1'b1);
      put_word(CMD_CLEAR,  8'h55, 1'b1);
      put_word(CMD_REPORT, 8'h00, 1'b1);
      put_word(CMD_APPEND, 8'hAA, 1'b1);
      put_word(CMD_FEED,   8'hAA, 1'b1);
      put_word(CMD_REPORT, 8'h00, 1'b1);
      put_word(CMD_CLEAR,  8'hFF, 1'b1);

      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 7) == 0) begin
            noise_n = $urandom_range(1, 6);
            repeat (noise_n) put_word(2'($urandom_range(0, 3)), 8'($urandom), 1'b1);
         end
         run_pair();
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // receiver; one long hold-off so the block backs up and stalls reports
   initial begin
      int wait_n;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT) wait_n = HOLD_CYCLES;
         else wait_n = rx_burst ? 0 : $urandom_range(0, 8);
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      end
   end

endmodule

### filelist.f
rtl/ede_pkg.sv
rtl/ede_cell.sv
rtl/edit_distance_engine_top.sv
tb/edit_distance_checker.sv
tb/tb_edit_distance_engine_top.sv
